>>> sv/smx_pkg.sv
// ----------------------------------------------------------------------------
// Stack machine execute package
// Shared sizes, operation and status codes, and the command bundle that
// the controller sends to the datapath.
// ----------------------------------------------------------------------------
package smx_pkg;

    // Stack geometry and word size.
    localparam int STACK_DEPTH = 64;
    localparam int WORD_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;

    // Operation codes; the codes above OP_NOP behave as no operation.
    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_ADD  = 3'd2,
        OP_MUL  = 3'd3,
        OP_NOP  = 3'd4
    } op_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // take the input request and start the stack read
        logic commit;   // update the stack and load the result register
    } smx_cmd_t;

endpackage

>>> sv/smx_instr_if.sv
// ----------------------------------------------------------------------------
// Instruction channel
// Valid/ready channel that carries one instruction request.
// ----------------------------------------------------------------------------
interface smx_instr_if
    import smx_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic [WORD_W-1:0]        mem_address;
    logic signed [WORD_W-1:0] read_value;

    modport source (output valid, output operation, output mem_address,
                    output read_value, input ready);
    modport sink   (input valid, input operation, input mem_address,
                    input read_value, output ready);
endinterface

>>> sv/smx_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the result of one instruction.
// ----------------------------------------------------------------------------
interface smx_result_if
    import smx_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic                     write_enable;
    logic [WORD_W-1:0]        write_address;
    logic signed [WORD_W-1:0] write_value;
    logic signed [WORD_W-1:0] top_value;
    logic [CNT_W-1:0]         stack_count;

    modport source (output valid, output status, output write_enable,
                    output write_address, output write_value,
                    output top_value, output stack_count, input ready);
    modport sink   (input valid, input status, input write_enable,
                    input write_address, input write_value,
                    input top_value, input stack_count, output ready);
endinterface

>>> sv/stack_machine_execute.sv
// A taken instruction request is captured along with a registered read of the
// stack entry below the top, then committed to the stack and the result register
// once that register is free; no new request is taken before that commit.
// A result waiting on the output does not block the next request.
// Reset clears the entry count and the handshake state; the stack memory is
// not cleared, and the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// Stack machine execute core
// Zero-address stack machine: push, pop, add, multiply and no operation on
// a bounded stack of 32-bit words, with underflow and overflow flagged.
// ----------------------------------------------------------------------------
module stack_machine_execute
    import smx_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    smx_instr_if.sink    instr,
    smx_result_if.source result
);

    smx_cmd_t cmd;

    // Sequencer.
    smx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (instr.valid),
        .in_ready  (instr.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // Stack and arithmetic.
    smx_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .operation     (instr.operation),
        .mem_address   (instr.mem_address),
        .read_value    (instr.read_value),
        .status        (result.status),
        .write_enable  (result.write_enable),
        .write_address (result.write_address),
        .write_value   (result.write_value),
        .top_value     (result.top_value),
        .stack_count   (result.stack_count)
    );

endmodule

>>> sv/smx_ctrl.sv
// ----------------------------------------------------------------------------
// Stack machine controller
// Two-state sequencer: takes one instruction request, lets the stack read
// complete, then commits the result once the result register is free.
// ----------------------------------------------------------------------------
module smx_ctrl
    import smx_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output smx_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // Handshake and commands.
    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign cmd.capture = in_valid && in_ready;
    assign cmd.commit  = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    // Next state and result valid flag.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.commit)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // A request is never taken in the same cycle as a commit.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");

    // A new result only appears after a commit.
    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result valid without commit");

    // A capture is always followed by the execute state.
    a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == S_EXEC))
        else $error("capture did not enter execute");
`endif

endmodule

>>> sv/smx_datapath.sv
// ----------------------------------------------------------------------------
// Stack machine datapath
// Holds the top of stack in a register and the entries below it in a
// memory. The second entry is read when a request is captured, and the
// stack, count and result register are updated on commit.
// ----------------------------------------------------------------------------
module smx_datapath
    import smx_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  smx_cmd_t                 cmd,
    input  logic [OP_W-1:0]          operation,
    input  logic [WORD_W-1:0]        mem_address,
    input  logic signed [WORD_W-1:0] read_value,
    output logic [STATUS_W-1:0]      status,
    output logic                     write_enable,
    output logic [WORD_W-1:0]        write_address,
    output logic signed [WORD_W-1:0] write_value,
    output logic signed [WORD_W-1:0] top_value,
    output logic [CNT_W-1:0]         stack_count
);

    // Captured request.
    logic [OP_W-1:0]   op_reg;
    logic [WORD_W-1:0] addr_reg;
    logic [WORD_W-1:0] rval_reg;

    // Stack state: entry count, top word, and the entries below the top.
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [WORD_W-1:0] top_reg;
    logic [WORD_W-1:0] top_next;
    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // Result register.
    status_t           status_reg;
    logic              wen_reg;
    logic [WORD_W-1:0] waddr_reg;
    logic [WORD_W-1:0] wval_reg;
    logic [WORD_W-1:0] top_out_reg;
    logic [CNT_W-1:0]  count_out_reg;

    // Execute stage signals.
    status_t           status_next;
    logic              wen_next;
    logic              push_we;
    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  count_m2;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] prod;

    assign count_m1 = count_reg - CNT_W'(1);
    assign count_m2 = count_reg - CNT_W'(2);
    assign rd_addr  = count_m2[ADDR_W-1:0];
    assign wr_addr  = count_m1[ADDR_W-1:0];
    assign sum      = top_reg + rd_data_reg;
    assign prod     = WORD_W'(top_reg * rd_data_reg);

    // Capture the request and read the entry just below the top.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= operation;
            addr_reg    <= mem_address;
            rval_reg    <= read_value;
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Execute one instruction against the stack.
    always_comb
    begin
        status_next = ST_DONE;
        wen_next    = 1'b0;
        push_we     = 1'b0;
        count_next  = count_reg;
        top_next    = top_reg;
        case (op_reg)
            OP_PUSH:
            begin
                if (count_reg >= CNT_W'(STACK_DEPTH))
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    push_we    = (count_reg != '0);
                    top_next   = rval_reg;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_UNDER;
                end
                else
                begin
                    wen_next   = 1'b1;
                    top_next   = rd_data_reg;
                    count_next = count_m1;
                end
            end
            OP_ADD, OP_MUL:
            begin
                if (count_reg < CNT_W'(2))
                begin
                    status_next = ST_UNDER;
                end
                else
                begin
                    top_next   = (op_reg == OP_ADD) ? sum : prod;
                    count_next = count_m1;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    // Stack count is control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    // Top word, spill of the old top on push, and the result register.
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            top_reg <= top_next;
            if (push_we)
            begin
                mem[wr_addr] <= top_reg;
            end
            status_reg    <= status_next;
            wen_reg       <= wen_next;
            waddr_reg     <= wen_next ? addr_reg : '0;
            wval_reg      <= wen_next ? top_reg : '0;
            top_out_reg   <= (count_next == '0) ? '0 : top_next;
            count_out_reg <= count_next;
        end
    end

    assign status        = status_reg;
    assign write_enable  = wen_reg;
    assign write_address = waddr_reg;
    assign write_value   = wval_reg;
    assign top_value     = top_out_reg;
    assign stack_count   = count_out_reg;

`ifndef SYNTHESIS
    // The count never exceeds the stack depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    // The stack only changes on a commit.
    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(count_reg))
        else $error("stack count changed without commit");

    // A commit moves the count by at most one entry.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (count_reg == $past(count_reg)
                        || count_reg == $past(count_reg) + CNT_W'(1)
                        || count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("stack count moved by more than one");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack machine execute testbench
// Drives instruction requests into the execute core and checks every result
// against an in-bench model of the stack. Directed tests cover empty and
// one-entry underflow, spare operation codes and wrapping arithmetic.
// Random programs then fill the stack past its depth and drain it below
// empty, with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import smx_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int IDLE_PCT    = 13;

    // Expected contents of one result request.
    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                write_enable;
        logic [WORD_W-1:0]   write_address;
        logic [WORD_W-1:0]   write_value;
        logic [WORD_W-1:0]   top_value;
        logic [CNT_W-1:0]    stack_count;
    } exec_result_t;

    logic clk = 1'b0;
    logic rst_n;

    smx_instr_if  instr_ch ();
    smx_result_if result_ch ();

    stack_machine_execute dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    // Model of the stack, updated as each instruction request is taken.
    logic [WORD_W-1:0] stack_words [STACK_DEPTH];
    int                word_count = 0;

    exec_result_t expected_results [$];
    int  mismatches    = 0;
    int  cycle_count   = 0;
    int  ops_sent      = 0;
    int  status_seen [3] = '{0, 0, 0};
    int  writes_seen   = 0;
    int  deepest       = 0;
    bit  no_idle       = 1'b0;

    // Clock: 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Runaway guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Execute one instruction on the model stack and return its result.
    function automatic exec_result_t execute_instr(input logic [OP_W-1:0] op,
                                                   input logic [WORD_W-1:0] addr,
                                                   input logic [WORD_W-1:0] value);
        exec_result_t      res;
        logic [WORD_W-1:0] upper;
        logic [WORD_W-1:0] lower;
        res.status        = ST_DONE;
        res.write_enable  = 1'b0;
        res.write_address = '0;
        res.write_value   = '0;
        case (op)
            OP_PUSH:
            begin
                if (word_count >= STACK_DEPTH)
                    res.status = ST_OVER;
                else
                begin
                    stack_words[word_count] = value;
                    word_count++;
                end
            end
            OP_POP:
            begin
                if (word_count == 0)
                    res.status = ST_UNDER;
                else
                begin
                    word_count--;
                    res.write_enable  = 1'b1;
                    res.write_address = addr;
                    res.write_value   = stack_words[word_count];
                end
            end
            OP_ADD, OP_MUL:
            begin
                if (word_count < 2)
                    res.status = ST_UNDER;
                else
                begin
                    upper = stack_words[word_count - 1];
                    lower = stack_words[word_count - 2];
                    word_count--;
                    // Both operations wrap to the word width.
                    if (op == OP_ADD)
                        stack_words[word_count - 1] = upper + lower;
                    else
                        stack_words[word_count - 1] = upper * lower;
                end
            end
            default:
            begin
            end
        endcase
        res.top_value   = (word_count == 0) ? '0 : stack_words[word_count - 1];
        res.stack_count = CNT_W'(word_count);
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Predict on each taken instruction request and check each result request.
    always @(posedge clk)
    begin : track_results
        exec_result_t want;
        if (rst_n)
        begin
            if (instr_ch.valid && instr_ch.ready)
            begin
                expected_results.push_back(execute_instr(instr_ch.operation,
                                                         instr_ch.mem_address,
                                                         instr_ch.read_value));
                if (word_count > deepest)
                    deepest = word_count;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual status %h",
                             $time, result_ch.status);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", WORD_W'(want.status), WORD_W'(result_ch.status));
                    compare_field("write_enable", WORD_W'(want.write_enable),
                                  WORD_W'(result_ch.write_enable));
                    compare_field("write_address", want.write_address,
                                  result_ch.write_address);
                    compare_field("write_value", want.write_value, result_ch.write_value);
                    compare_field("top_value", want.top_value, result_ch.top_value);
                    compare_field("stack_count", WORD_W'(want.stack_count),
                                  WORD_W'(result_ch.stack_count));
                    if (want.status <= ST_OVER)
                        status_seen[want.status]++;
                    if (want.write_enable)
                        writes_seen++;
                end
            end
        end
    end

    // Result side backpressure.
    always @(negedge clk)
        result_ch.ready <= rst_n && (no_idle || $urandom_range(99) >= IDLE_PCT);

    // Send one instruction request, with a random gap ahead of it.
    task automatic send_instr(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] addr,
                              input logic [WORD_W-1:0] value);
        int gap;
        gap = (!no_idle && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        instr_ch.valid       <= 1'b1;
        instr_ch.operation   <= op;
        instr_ch.mem_address <= addr;
        instr_ch.read_value  <= value;
        do
            @(posedge clk);
        while (!instr_ch.ready);
        @(negedge clk);
        if (op <= OP_MUL)
            ops_sent++;
    endtask

    // Random word, leaning toward the extremes now and then.
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(WORD_W - 1){1'b0}}};
            3:       return {1'b0, {(WORD_W - 1){1'b1}}};
            4:       return WORD_W'(1);
            default: return $urandom;
        endcase
    endfunction

    // Weighted choice of operation; the remainder goes to the no-op codes.
    function automatic logic [OP_W-1:0] pick_op(input int push_w, input int pop_w,
                                                input int arith_w);
        int roll;
        roll = $urandom_range(99);
        if (roll < push_w)
            return OP_PUSH;
        if (roll < push_w + pop_w)
            return OP_POP;
        if (roll < push_w + pop_w + arith_w)
            return $urandom_range(1) ? OP_ADD : OP_MUL;
        return OP_W'($urandom_range(2 ** OP_W - 1, OP_NOP));
    endfunction

    // Underflow from an empty and a one-entry stack, and the no-op codes.
    task automatic test_empty_stack();
        send_instr(OP_POP, $urandom, $urandom);
        send_instr(OP_ADD, $urandom, $urandom);
        send_instr(OP_MUL, $urandom, $urandom);
        for (int code = OP_NOP; code < 2 ** OP_W; code++)
            send_instr(OP_W'(code), $urandom, $urandom);
        send_instr(OP_PUSH, '0, {1'b1, {(WORD_W - 1){1'b0}}});
        send_instr(OP_ADD, '1, $urandom);
        send_instr(OP_MUL, '1, $urandom);
        send_instr(OP_POP, '0, $urandom);
    endtask

    // Add and multiply across the wrap points, pops to extreme addresses.
    task automatic test_wrapping_arith();
        send_instr(OP_PUSH, '0, {1'b0, {(WORD_W - 1){1'b1}}});
        send_instr(OP_PUSH, '0, WORD_W'(1));
        send_instr(OP_ADD, '0, '0);
        send_instr(OP_PUSH, '0, '1);
        send_instr(OP_MUL, '0, '0);
        send_instr(OP_PUSH, '0, '0);
        send_instr(OP_ADD, '0, '0);
        send_instr(OP_POP, '1, '0);
        send_instr(OP_PUSH, '0, '1);
        send_instr(OP_PUSH, '1, '1);
        send_instr(OP_MUL, '0, '0);
        send_instr(OP_PUSH, '0, {(WORD_W / 2){2'b10}});
        send_instr(OP_POP, {(WORD_W / 2){2'b01}}, '0);
        send_instr(OP_POP, '0, '1);
    endtask

    // Random programs in phases that fill, drain, mix or run past both bounds.
    task automatic test_random_programs(input int count);
        int start;
        int span;
        start = ops_sent;
        while (ops_sent - start < count)
        begin
            span = $urandom_range(10, 80);
            case ($urandom_range(4))
                0: repeat (span) send_instr(pick_op(70, 10, 16), $urandom, rand_word());
                1: repeat (span) send_instr(pick_op(15, 40, 40), $urandom, rand_word());
                2: repeat (span) send_instr(pick_op(40, 25, 30), $urandom, rand_word());
                3: repeat (span) send_instr(OP_W'($urandom), $urandom, $urandom);
                default:
                begin
                    // Fill to the top, push past it, then drain below empty.
                    while (word_count < STACK_DEPTH)
                        send_instr(OP_PUSH, $urandom, rand_word());
                    repeat ($urandom_range(1, 3))
                        send_instr(OP_PUSH, $urandom, rand_word());
                    while (word_count > 0)
                        send_instr(pick_op(0, 60, 40), $urandom, rand_word());
                    repeat ($urandom_range(1, 2))
                        send_instr(pick_op(0, 50, 50), $urandom, rand_word());
                end
            endcase
        end
    endtask

    // A long stretch with both channels always willing.
    task automatic test_unbroken_burst(input int count);
        int start;
        no_idle = 1'b1;
        start   = ops_sent;
        while (ops_sent - start < count)
            send_instr(pick_op(45, 25, 28), $urandom, rand_word());
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n                = 1'b0;
        instr_ch.valid       = 1'b0;
        instr_ch.operation   = OP_NOP;
        instr_ch.mem_address = '0;
        instr_ch.read_value  = '0;
        result_ch.ready      = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_stack();
        test_wrapping_arith();
        test_random_programs(1600);
        test_unbroken_burst(300);
        instr_ch.valid <= 1'b0;

        // Let the remaining results drain, then wait with no traffic before reporting.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("Ran %0d stack instructions: %0d done, %0d underflow, %0d overflow",
                 ops_sent, status_seen[ST_DONE], status_seen[ST_UNDER], status_seen[ST_OVER]);
        $display("Deepest stack %0d of %0d, %0d memory writes from pops",
                 deepest, STACK_DEPTH, writes_seen);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
